// File: sv/analog_key_rapid_trigger_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the analog key rapid-trigger block
// Clocked on clk and disabled while rst_n is low in the scope of use.
// ----------------------------------------------------------------------------
`ifndef ANALOG_KEY_RAPID_TRIGGER_DEFINES_SVH
`define ANALOG_KEY_RAPID_TRIGGER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AKRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("akrt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AKRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("akrt: next-cycle check failed");

`endif

// File: sv/akrt_pkg.sv
// ----------------------------------------------------------------------------
// akrt_pkg
// Types, codes and fixed tables of the analog key rapid-trigger block.
// ----------------------------------------------------------------------------
package akrt_pkg;

  localparam int KEY_COUNT  = 17;
  localparam int KEY_W      = $clog2(KEY_COUNT);
  localparam int SAMPLE_W   = 12;
  localparam int SENS_W     = 10;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [7:0]          ALL_KEYS     = 8'd255;
  localparam logic [SENS_W-1:0]   SENS_RESET   = 10'd50;
  localparam logic [SENS_W-1:0]   SENS_MIN     = 10'd1;
  localparam logic [SENS_W-1:0]   SENS_MAX     = 10'd1000;
  localparam logic [SAMPLE_W-1:0] MARGIN_RESET = 12'd30;

  // Bit 7 marks a mapped channel, the low bits hold the key number.
  localparam logic [7:0] CHAN_MAP [2][16] = '{
    '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h88, 8'h87, 8'h86, 8'h85, 8'h84, 8'h83, 8'h82, 8'h81},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h90, 8'h8F, 8'h8E, 8'h8D, 8'h8C, 8'h8B, 8'h8A, 8'h89}
  };

  localparam logic [7:0] USAGE_TAB [32] = '{
    8'h62, 8'h63, 8'h58, 8'h5B, 8'h5A, 8'h59, 8'h5E, 8'h5D,
    8'h5C, 8'h57, 8'h61, 8'h60, 8'h5F, 8'h56, 8'h55, 8'h54,
    8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [1:0]          req_type;
    logic                mux_source;
    logic [3:0]          mux_channel;
    logic [SAMPLE_W-1:0] adc_value;
    logic [7:0]          key_select;
    logic [SENS_W-1:0]   sens_value;
  } akrt_req_t;

  typedef struct packed {
    logic                 hit;
    logic [4:0]           key_number;
    logic [7:0]           usage_code;
    logic                 pressed;
    logic [KEY_COUNT-1:0] pressed_mask;
    logic [SENS_W-1:0]    sens_readback;
  } akrt_result_t;

endpackage

// File: sv/akrt_if.sv
// ----------------------------------------------------------------------------
// akrt channel interfaces
// Request, result and configuration channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface akrt_in_if import akrt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic                mux_source;
  logic [3:0]          mux_channel;
  logic [SAMPLE_W-1:0] adc_value;
  logic [7:0]          key_select;
  logic [SENS_W-1:0]   sens_value;

  modport source(output valid, req_type, mux_source, mux_channel, adc_value,
                 key_select, sens_value, input ready);
  modport sink(input valid, req_type, mux_source, mux_channel, adc_value,
               key_select, sens_value, output ready);
endinterface

interface akrt_out_if import akrt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [4:0]           key_number;
  logic [7:0]           usage_code;
  logic                 pressed;
  logic [KEY_COUNT-1:0] pressed_mask;
  logic [SENS_W-1:0]    sens_readback;

  modport source(output valid, hit, key_number, usage_code, pressed, pressed_mask,
                 sens_readback, input ready);
  modport sink(input valid, hit, key_number, usage_code, pressed, pressed_mask,
               sens_readback, output ready);
endinterface

interface akrt_cfg_if import akrt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] idle_margin;

  modport source(output valid, idle_margin, input ready);
  modport sink(input valid, idle_margin, output ready);
endinterface

// File: sv/akrt_in_stage.sv
// ----------------------------------------------------------------------------
// akrt_in_stage
// Input register: captures one request word and holds it until it is used.
// ----------------------------------------------------------------------------
module akrt_in_stage import akrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  akrt_in_if.sink   in_ch,
  input  logic      step_en,
  output akrt_req_t req,
  output logic      req_valid
);

  logic      valid_r;
  logic      valid_nxt;
  akrt_req_t req_r;
  logic      take;

  assign in_ch.ready = !valid_r || step_en;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = take || (valid_r && !step_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r.req_type    <= in_ch.req_type;
      req_r.mux_source  <= in_ch.mux_source;
      req_r.mux_channel <= in_ch.mux_channel;
      req_r.adc_value   <= in_ch.adc_value;
      req_r.key_select  <= in_ch.key_select;
      req_r.sens_value  <= in_ch.sens_value;
    end
  end

  assign req       = req_r;
  assign req_valid = valid_r;

endmodule

// File: sv/akrt_key_engine.sv
// ----------------------------------------------------------------------------
// akrt_key_engine
// Per-key tracking state and the combinational update for one request.
// ----------------------------------------------------------------------------
module akrt_key_engine import akrt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  akrt_req_t           req,
  input  logic [SAMPLE_W-1:0] idle_margin,
  output akrt_result_t        result
);

  logic [SAMPLE_W-1:0] base_r [KEY_COUNT];
  logic [SAMPLE_W-1:0] shal_r [KEY_COUNT];
  logic [SAMPLE_W-1:0] deep_r [KEY_COUNT];
  logic [SENS_W-1:0]   sens_r [KEY_COUNT];
  logic [KEY_COUNT-1:0] act_r;
  logic [KEY_COUNT-1:0] cal_r;

  logic [7:0]          map_e;
  logic                is_sample, is_set, is_read;
  logic                sample_hit, sel_valid, set_all, named;
  logic [KEY_W-1:0]    tgt;
  logic [SAMPLE_W-1:0] v, base_c, shal_c, deep_c, d_max, s_min, b_min;
  logic [SENS_W-1:0]   sens_c, sens_clamp;
  logic                act_c, cal_c;
  logic [SAMPLE_W:0]   floor_lvl, rel_sum, press_sum;
  logic [SAMPLE_W-1:0] base_nxt, shal_nxt, deep_nxt;
  logic                act_nxt;
  logic [KEY_COUNT-1:0] mask;

  always_comb begin
    is_sample  = (req.req_type == REQ_SAMPLE);
    is_set     = (req.req_type == REQ_SET);
    is_read    = (req.req_type == REQ_READ);
    map_e      = CHAN_MAP[req.mux_source][req.mux_channel];
    sample_hit = is_sample && map_e[7] && (map_e[6:0] < 7'(KEY_COUNT));
    sel_valid  = req.key_select < 8'(KEY_COUNT);
    set_all    = is_set && (req.key_select == ALL_KEYS);
    named      = sample_hit || ((is_set || is_read) && sel_valid);
    tgt        = is_sample ? map_e[KEY_W-1:0] : req.key_select[KEY_W-1:0];

    if (req.sens_value < SENS_MIN) begin
      sens_clamp = SENS_MIN;
    end else if (req.sens_value > SENS_MAX) begin
      sens_clamp = SENS_MAX;
    end else begin
      sens_clamp = req.sens_value;
    end

    v      = req.adc_value;
    base_c = base_r[tgt];
    shal_c = shal_r[tgt];
    deep_c = deep_r[tgt];
    sens_c = sens_r[tgt];
    act_c  = act_r[tgt];
    cal_c  = cal_r[tgt];

    d_max     = (v > deep_c) ? v : deep_c;
    s_min     = (v < shal_c) ? v : shal_c;
    b_min     = (v < base_c) ? v : base_c;
    floor_lvl = {1'b0, b_min} + {1'b0, idle_margin};
    rel_sum   = {1'b0, v} + (SAMPLE_W+1)'(sens_c);
    press_sum = {1'b0, s_min} + (SAMPLE_W+1)'(sens_c);

    base_nxt = b_min;
    shal_nxt = s_min;
    deep_nxt = d_max;
    act_nxt  = act_c;
    if (!cal_c) begin
      // First reading of a key sets its baseline and both peaks.
      base_nxt = v;
      shal_nxt = v;
      deep_nxt = v;
    end else if (act_c) begin
      if (rel_sum < {1'b0, d_max}) begin
        act_nxt  = 1'b0;
        shal_nxt = v;
      end
    end else begin
      if (({1'b0, v} > press_sum) && ({1'b0, v} > floor_lvl)) begin
        act_nxt  = 1'b1;
        deep_nxt = v;
      end
      // At or below the floor an idle key is forced back to a clean idle state.
      if ({1'b0, v} <= floor_lvl) begin
        act_nxt  = 1'b0;
        deep_nxt = v;
        shal_nxt = v;
      end
    end

    mask = act_r;
    if (sample_hit) begin
      mask[tgt] = act_nxt;
    end

    result.hit           = named || set_all;
    result.key_number    = named ? 5'(tgt) : 5'd0;
    result.usage_code    = named ? USAGE_TAB[5'(tgt)] : 8'd0;
    result.pressed       = sample_hit ? act_nxt : (named && act_c);
    result.pressed_mask  = mask;
    result.sens_readback = (is_read && sel_valid) ? sens_c : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        base_r[k] <= '0;
        shal_r[k] <= '0;
        deep_r[k] <= '0;
        sens_r[k] <= SENS_RESET;
      end
      act_r <= '0;
      cal_r <= '0;
    end else if (step_en) begin
      if (sample_hit) begin
        base_r[tgt] <= base_nxt;
        shal_r[tgt] <= shal_nxt;
        deep_r[tgt] <= deep_nxt;
        act_r[tgt]  <= act_nxt;
        cal_r[tgt]  <= 1'b1;
      end
      if (set_all) begin
        for (int k = 0; k < KEY_COUNT; k++) begin
          sens_r[k] <= sens_clamp;
        end
      end else if (is_set && sel_valid) begin
        sens_r[tgt] <= sens_clamp;
      end
    end
  end

endmodule

// File: sv/akrt_out_stage.sv
// ----------------------------------------------------------------------------
// akrt_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module akrt_out_stage import akrt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  akrt_result_t result,
  input  logic         load,
  output logic         space,
  akrt_out_if.source   out_ch
);

  logic         valid_r;
  logic         valid_nxt;
  akrt_result_t res_r;

  assign space     = !valid_r || out_ch.ready;
  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.hit           = res_r.hit;
  assign out_ch.key_number    = res_r.key_number;
  assign out_ch.usage_code    = res_r.usage_code;
  assign out_ch.pressed       = res_r.pressed;
  assign out_ch.pressed_mask  = res_r.pressed_mask;
  assign out_ch.sens_readback = res_r.sens_readback;

endmodule

// File: sv/analog_key_rapid_trigger.sv
// ----------------------------------------------------------------------------
// analog_key_rapid_trigger
// Rapid-trigger press detection for 17 Hall-effect keys.
// ----------------------------------------------------------------------------
// Requests enter on in_ch: sensor samples (source, channel, reading), sets of
// a key's sensitivity, or reads of it. Each request word gives exactly one
// result word on out_ch with hit, key number, usage code, the key's state and
// the mask of all pressed keys. cfg_ch writes the noise margin; it is always
// ready and is to be written only while no request is in flight.
// An accepted word is loaded into the input register; the key update then
// fills the result register from it as soon as that register has space, and
// out_ch.valid rises once the result register holds the word.
// One word is accepted every cycle while the receiver keeps taking results;
// the key state is held in flops and updated combinationally for each word.
// A stalled receiver holds the result register, the input register still
// takes one more word, and only then does in_ch.ready drop.
// Synchronous reset clears all key state, sets every sensitivity to 50 and
// the noise margin to 30; both channels come out of reset empty.
// ----------------------------------------------------------------------------
module analog_key_rapid_trigger import akrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  akrt_in_if.sink    in_ch,
  akrt_out_if.source out_ch,
  akrt_cfg_if.sink   cfg_ch
);

  akrt_req_t           req;
  logic                req_valid;
  akrt_result_t        result;
  logic                out_space;
  logic                step_en;
  logic [SAMPLE_W-1:0] margin_r;

  assign step_en      = req_valid && out_space;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      margin_r <= cfg_ch.idle_margin;
    end
  end

  akrt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .step_en  (step_en),
    .req      (req),
    .req_valid(req_valid)
  );

  akrt_key_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .req        (req),
    .idle_margin(margin_r),
    .result     (result)
  );

  akrt_out_stage u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .result(result),
    .load  (step_en),
    .space (out_space),
    .out_ch(out_ch)
  );

endmodule

// File: sv/akrt_checker.sv
// ----------------------------------------------------------------------------
// akrt_checker
// Port-level checks on the result channel of the rapid-trigger block.
// ----------------------------------------------------------------------------
`include "analog_key_rapid_trigger_defines.svh"

module akrt_checker import akrt_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 hit,
  input logic [4:0]           key_number,
  input logic [7:0]           usage_code,
  input logic                 pressed,
  input logic [KEY_COUNT-1:0] pressed_mask,
  input logic [SENS_W-1:0]    sens_readback
);

  `AKRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `AKRT_ASSERT_NOW(a_miss_clean, out_valid && !hit,
                   key_number == 5'd0 && usage_code == 8'd0 && !pressed)
  `AKRT_ASSERT_NOW(a_pressed_in_mask, out_valid && pressed, hit && pressed_mask[key_number])
  `AKRT_ASSERT_NOW(a_readback_range, out_valid && sens_readback != '0,
                   hit && !pressed_mask[KEY_COUNT-1] || hit && sens_readback <= SENS_MAX)

endmodule

bind analog_key_rapid_trigger akrt_checker u_akrt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .hit          (out_ch.hit),
  .key_number   (out_ch.key_number),
  .usage_code   (out_ch.usage_code),
  .pressed      (out_ch.pressed),
  .pressed_mask (out_ch.pressed_mask),
  .sens_readback(out_ch.sens_readback)
);

// File: tb/sv/tb_analog_key_rapid_trigger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_analog_key_rapid_trigger
// Self-checking bench for the rapid-trigger key block. A table of directed
// requests covers the extremes and corner cases, then random phases replay
// key-travel waveforms under several noise margins. Every result word is
// compared field by field with a fixed result or an in-bench key-tracker model.
// ----------------------------------------------------------------------------
module tb_analog_key_rapid_trigger;
  import akrt_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         ADC_TOP     = (1 << SAMPLE_W) - 1;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DIRECTED_ROWS = 25;
  localparam akrt_result_t NO_RESULT = '0;

  typedef struct {
    akrt_req_t    req;
    bit           fixed;
    akrt_result_t res;
  } stim_row_t;

  // Rows with fixed set carry their result; the others go through the model.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{REQ_READ, 1'b0, 4'd0, 12'd0, 8'd0, 10'd0}, 1'b1,
      '{1'b1, 5'd0, 8'h62, 1'b0, 17'd0, 10'd50}},
    '{'{REQ_READ, 1'b0, 4'd0, 12'd0, 8'd17, 10'd0}, 1'b1, NO_RESULT},
    '{'{REQ_READ, 1'b1, 4'd15, 12'd4095, 8'd255, 10'd1023}, 1'b1, NO_RESULT},
    '{'{REQ_UNUSED, 1'b1, 4'd15, 12'd4095, 8'd255, 10'd1023}, 1'b1, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b0, 4'd1, 12'd4095, 8'd0, 10'd0}, 1'b1, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b1, 4'd0, 12'd4095, 8'd0, 10'd0}, 1'b1, NO_RESULT},
    '{'{REQ_SET, 1'b0, 4'd0, 12'd0, 8'd255, 10'd0}, 1'b1,
      '{1'b1, 5'd0, 8'h00, 1'b0, 17'd0, 10'd0}},
    '{'{REQ_READ, 1'b0, 4'd0, 12'd0, 8'd16, 10'd0}, 1'b1,
      '{1'b1, 5'd16, 8'h53, 1'b0, 17'd0, 10'd1}},
    '{'{REQ_SET, 1'b0, 4'd0, 12'd0, 8'd16, 10'd1023}, 1'b1,
      '{1'b1, 5'd16, 8'h53, 1'b0, 17'd0, 10'd0}},
    '{'{REQ_READ, 1'b0, 4'd0, 12'd0, 8'd16, 10'd0}, 1'b1,
      '{1'b1, 5'd16, 8'h53, 1'b0, 17'd0, 10'd1000}},
    '{'{REQ_SET, 1'b0, 4'd0, 12'd0, 8'd17, 10'd100}, 1'b1, NO_RESULT},
    '{'{REQ_SET, 1'b0, 4'd0, 12'd0, 8'd255, 10'd50}, 1'b1,
      '{1'b1, 5'd0, 8'h00, 1'b0, 17'd0, 10'd0}},
    '{'{REQ_SAMPLE, 1'b0, 4'd0, 12'd0, 8'd0, 10'd0}, 1'b1,
      '{1'b1, 5'd0, 8'h62, 1'b0, 17'd0, 10'd0}},
    '{'{REQ_SAMPLE, 1'b0, 4'd0, 12'd4095, 8'd0, 10'd0}, 1'b1,
      '{1'b1, 5'd0, 8'h62, 1'b1, 17'h1, 10'd0}},
    '{'{REQ_SAMPLE, 1'b0, 4'd0, 12'd4060, 8'd0, 10'd0}, 1'b0, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b0, 4'd0, 12'd4000, 8'd0, 10'd0}, 1'b0, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b0, 4'd0, 12'd4060, 8'd0, 10'd0}, 1'b0, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b0, 4'd15, 12'd0, 8'd0, 10'd0}, 1'b0, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b0, 4'd15, 12'd60, 8'd0, 10'd0}, 1'b0, NO_RESULT},
    '{'{REQ_SET, 1'b0, 4'd0, 12'd0, 8'd1, 10'd1000}, 1'b0, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b0, 4'd15, 12'd0, 8'd0, 10'd0}, 1'b0, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b0, 4'd14, 12'd100, 8'd0, 10'd0}, 1'b0, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b0, 4'd14, 12'd130, 8'd0, 10'd0}, 1'b0, NO_RESULT},
    '{'{REQ_SAMPLE, 1'b1, 4'd8, 12'd4095, 8'd0, 10'd0}, 1'b0, NO_RESULT},
    '{'{REQ_SET, 1'b0, 4'd0, 12'd0, 8'd1, 10'd50}, 1'b0, NO_RESULT}
  };

  logic clk;
  logic rst_n;

  akrt_in_if  in_ch();
  akrt_out_if out_ch();
  akrt_cfg_if cfg_ch();

  analog_key_rapid_trigger DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Model of the key trackers.
  logic [SAMPLE_W-1:0] idle_margin;
  logic [SAMPLE_W-1:0] base_level [KEY_COUNT];
  logic [SAMPLE_W-1:0] shallow_pk [KEY_COUNT];
  logic [SAMPLE_W-1:0] deep_pk    [KEY_COUNT];
  logic [SENS_W-1:0]   key_sens   [KEY_COUNT];
  logic [KEY_COUNT-1:0] key_down;
  logic [KEY_COUNT-1:0] key_seen;

  akrt_result_t expected_reports [$];
  akrt_result_t next_report;

  // Where each key lives on the converters, and its random travel.
  logic       key_src  [KEY_COUNT];
  logic [3:0] key_chan [KEY_COUNT];
  int         walk_level  [KEY_COUNT];
  bit         walk_rising [KEY_COUNT];

  int fail_count;
  int cycle_count;
  int burst_left;
  bit hold_off_start;
  int hold_left;
  int rx_mode;
  int mode_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic akrt_result_t apply_to_keys(akrt_req_t r);
    akrt_result_t res;
    logic [7:0] entry;
    logic [SENS_W-1:0] sens_new;
    int k, j, v, base, shallow, deep, sens, floor_level;
    bit named;
    res = '0;
    named = 1'b0;
    k = 0;
    case (r.req_type)
      REQ_SAMPLE: begin
        entry = CHAN_MAP[r.mux_source][r.mux_channel];
        if (entry[7] && entry[6:0] < KEY_COUNT) begin
          k = entry[6:0];
          v = r.adc_value;
          named = 1'b1;
          res.hit = 1'b1;
          if (!key_seen[k]) begin
            base_level[k] = SAMPLE_W'(v);
            shallow_pk[k] = SAMPLE_W'(v);
            deep_pk[k] = SAMPLE_W'(v);
            key_seen[k] = 1'b1;
          end else begin
            base = base_level[k];
            shallow = shallow_pk[k];
            deep = deep_pk[k];
            sens = key_sens[k];
            if (v > deep) deep = v;
            if (v < shallow) shallow = v;
            if (v < base) base = v;
            floor_level = base + int'(idle_margin);
            if (key_down[k]) begin
              // Release compares reading plus sensitivity, so no wrap near zero.
              if (v + sens < deep) begin
                key_down[k] = 1'b0;
                shallow = v;
              end
            end else begin
              if (v > shallow + sens && v > floor_level) begin
                key_down[k] = 1'b1;
                deep = v;
              end
              if (v <= floor_level) begin
                key_down[k] = 1'b0;
                deep = v;
                shallow = v;
              end
            end
            base_level[k] = SAMPLE_W'(base);
            shallow_pk[k] = SAMPLE_W'(shallow);
            deep_pk[k] = SAMPLE_W'(deep);
          end
        end
      end
      REQ_SET: begin
        if (r.sens_value < SENS_MIN) sens_new = SENS_MIN;
        else if (r.sens_value > SENS_MAX) sens_new = SENS_MAX;
        else sens_new = r.sens_value;
        if (r.key_select == ALL_KEYS) begin
          for (j = 0; j < KEY_COUNT; j++) key_sens[j] = sens_new;
          res.hit = 1'b1;
        end else if (r.key_select < KEY_COUNT) begin
          k = r.key_select;
          key_sens[k] = sens_new;
          named = 1'b1;
          res.hit = 1'b1;
        end
      end
      REQ_READ: begin
        if (r.key_select < KEY_COUNT) begin
          k = r.key_select;
          res.sens_readback = key_sens[k];
          named = 1'b1;
          res.hit = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (named) begin
      res.key_number = 5'(k);
      res.usage_code = USAGE_TAB[k];
      res.pressed = key_down[k];
    end
    res.pressed_mask = key_down;
    return res;
  endfunction

  task automatic offer_request(akrt_req_t r, bit may_idle, bit fixed,
                               akrt_result_t fixed_res);
    int gap;
    akrt_result_t predicted;
    if (may_idle && burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_ch.req_type    = r.req_type;
    in_ch.mux_source  = r.mux_source;
    in_ch.mux_channel = r.mux_channel;
    in_ch.adc_value   = r.adc_value;
    in_ch.key_select  = r.key_select;
    in_ch.sens_value  = r.sens_value;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_to_keys(r);
    expected_reports.push_back(fixed ? fixed_res : predicted);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_idle_margin(logic [SAMPLE_W-1:0] margin);
    wait_for_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_ch.idle_margin = margin;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    idle_margin = margin;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_random_phase(int count, bit squeeze);
    akrt_req_t r;
    int i, k, pick, step;
    for (i = 0; i < count; i++) begin
      // The receiver holds off while words keep coming, then the sender drains.
      if (squeeze && i == 0) hold_off_start = 1'b1;
      if (squeeze && i == count / 2) wait_for_results();
      r.mux_source  = 1'($urandom_range(0, 1));
      r.mux_channel = 4'($urandom_range(0, 15));
      r.adc_value   = SAMPLE_W'($urandom_range(0, ADC_TOP));
      r.key_select  = 8'($urandom_range(0, 255));
      r.sens_value  = SENS_W'($urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        r.req_type = REQ_SAMPLE;
        k = $urandom_range(0, KEY_COUNT - 1);
        if ($urandom_range(0, 4) == 0) walk_rising[k] = ~walk_rising[k];
        case ($urandom_range(0, 15))
          0: walk_level[k] = 0;
          1: walk_level[k] = ADC_TOP;
          default: begin
            step = $urandom_range(0, 400);
            walk_level[k] += walk_rising[k] ? step : -step;
            if (walk_level[k] < 0) walk_level[k] = 0;
            if (walk_level[k] > ADC_TOP) walk_level[k] = ADC_TOP;
          end
        endcase
        r.mux_source  = key_src[k];
        r.mux_channel = key_chan[k];
        r.adc_value   = SAMPLE_W'(walk_level[k]);
      end else if (pick < 80) begin
        r.req_type = REQ_SAMPLE;
      end else if (pick < 90) begin
        r.req_type = REQ_SET;
        case ($urandom_range(0, 4))
          0: r.key_select = ALL_KEYS;
          1: begin
          end
          default: r.key_select = 8'($urandom_range(0, KEY_COUNT - 1));
        endcase
        case ($urandom_range(0, 3))
          0: begin
          end
          1: begin
            case ($urandom_range(0, 4))
              0: r.sens_value = 10'd0;
              1: r.sens_value = SENS_MIN;
              2: r.sens_value = SENS_MAX;
              3: r.sens_value = SENS_MAX + 10'd1;
              default: r.sens_value = 10'd1023;
            endcase
          end
          default: r.sens_value = SENS_W'($urandom_range(1, 120));
        endcase
      end else if (pick < 99) begin
        r.req_type = REQ_READ;
        if ($urandom_range(0, 3) != 0) r.key_select = 8'($urandom_range(0, KEY_COUNT - 1));
      end else begin
        r.req_type = REQ_UNUSED;
      end
      offer_request(r, !(squeeze && i < 40), 1'b0, NO_RESULT);
    end
  endtask

  // Receiver: a stall pattern that switches at random among four modes.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_start) begin
        hold_off_start = 1'b0;
        hold_left = 48;
      end
      if (mode_left <= 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case (rx_mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = ($urandom_range(0, 3) != 0);
          2: out_ch.ready = 1'($urandom_range(0, 1));
          default: out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("result word with no request outstanding");
        fail_count++;
      end else begin
        next_report = expected_reports.pop_front();
        if (out_ch.hit !== next_report.hit) begin
          $error("hit: expected %0d, got %0d", next_report.hit, out_ch.hit);
          fail_count++;
        end
        if (out_ch.key_number !== next_report.key_number) begin
          $error("key_number: expected %0d, got %0d", next_report.key_number,
                 out_ch.key_number);
          fail_count++;
        end
        if (out_ch.usage_code !== next_report.usage_code) begin
          $error("usage_code: expected 0x%02h, got 0x%02h", next_report.usage_code,
                 out_ch.usage_code);
          fail_count++;
        end
        if (out_ch.pressed !== next_report.pressed) begin
          $error("pressed: expected %0d, got %0d", next_report.pressed, out_ch.pressed);
          fail_count++;
        end
        if (out_ch.pressed_mask !== next_report.pressed_mask) begin
          $error("pressed_mask: expected 0x%05h, got 0x%05h", next_report.pressed_mask,
                 out_ch.pressed_mask);
          fail_count++;
        end
        if (out_ch.sens_readback !== next_report.sens_readback) begin
          $error("sens_readback: expected %0d, got %0d", next_report.sens_readback,
                 out_ch.sens_readback);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int s, c, k, i;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_SAMPLE;
    in_ch.mux_source = 1'b0;
    in_ch.mux_channel = 4'd0;
    in_ch.adc_value = '0;
    in_ch.key_select = 8'd0;
    in_ch.sens_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idle_margin = '0;
    fail_count = 0;
    cycle_count = 0;
    burst_left = 0;
    hold_off_start = 1'b0;
    hold_left = 0;
    mode_left = 0;
    idle_margin = MARGIN_RESET;
    key_down = '0;
    key_seen = '0;
    for (k = 0; k < KEY_COUNT; k++) begin
      base_level[k] = '0;
      shallow_pk[k] = '0;
      deep_pk[k] = '0;
      key_sens[k] = SENS_RESET;
      walk_level[k] = 0;
      walk_rising[k] = 1'b1;
    end
    for (s = 0; s < 2; s++)
      for (c = 0; c < 16; c++)
        if (CHAN_MAP[s][c][7]) begin
          key_src[CHAN_MAP[s][c][6:0]] = 1'(s);
          key_chan[CHAN_MAP[s][c][6:0]] = 4'(c);
        end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++)
      offer_request(directed_rows[i].req, 1'b1, directed_rows[i].fixed,
                    directed_rows[i].res);

    write_idle_margin('0);
    run_random_phase(80, 1'b0);
    write_idle_margin(SAMPLE_W'(ADC_TOP));
    run_random_phase(60, 1'b0);
    write_idle_margin(SAMPLE_W'($urandom_range(1, ADC_TOP - 1)));
    run_random_phase(90, 1'b1);
    write_idle_margin(12'd12);
    run_random_phase(80, 1'b0);
    write_idle_margin(MARGIN_RESET);
    run_random_phase(90, 1'b0);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/akrt_pkg.sv
sv/akrt_if.sv
sv/akrt_in_stage.sv
sv/akrt_key_engine.sv
sv/akrt_out_stage.sv
sv/analog_key_rapid_trigger.sv
sv/akrt_checker.sv
tb/sv/tb_analog_key_rapid_trigger.sv
